// File: sv/rvid_pkg.sv
// ----------------------------------------------------------------------------
// rvid_pkg - RV32I decoder shared definitions
// Opcodes, class and sub-operation codes, and the decoded-item struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rvid_pkg;

	// major opcodes (bits 6:0)
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// exact system words
	localparam logic [31:0] W_ECALL  = 32'h0000_0073;
	localparam logic [31:0] W_EBREAK = 32'h0010_0073;
	localparam logic [31:0] W_SRET   = 32'h1020_0073;
	localparam logic [31:0] W_MRET   = 32'h3020_0073;
	localparam logic [31:0] W_WFI    = 32'h1050_0073;

	// op_class codes
	localparam logic [3:0] CLS_ALU_REG = 4'd0;
	localparam logic [3:0] CLS_ALU_IMM = 4'd1;
	localparam logic [3:0] CLS_LOAD    = 4'd2;
	localparam logic [3:0] CLS_STORE   = 4'd3;
	localparam logic [3:0] CLS_LUI     = 4'd4;
	localparam logic [3:0] CLS_AUIPC   = 4'd5;
	localparam logic [3:0] CLS_JAL     = 4'd6;
	localparam logic [3:0] CLS_JALR    = 4'd7;
	localparam logic [3:0] CLS_BRANCH  = 4'd8;
	localparam logic [3:0] CLS_SYSTEM  = 4'd9;
	localparam logic [3:0] CLS_CSR     = 4'd10;

	// ALU sub-ops beyond the funct3 range
	localparam logic [3:0] ALU_SUB = 4'd8;
	localparam logic [3:0] ALU_SRA = 4'd9;

	// funct3 values used directly
	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SR  = 3'd5;
	localparam logic [2:0] F3_PRIV = 3'd0;
	localparam logic [2:0] F3_HLV  = 3'd4;

	// system sub-ops
	localparam logic [3:0] SYS_ECALL   = 4'd0;
	localparam logic [3:0] SYS_EBREAK  = 4'd1;
	localparam logic [3:0] SYS_SRET    = 4'd2;
	localparam logic [3:0] SYS_MRET    = 4'd3;
	localparam logic [3:0] SYS_WFI     = 4'd4;
	localparam logic [3:0] SYS_HOSTCALL = 4'd5;

	// csr sub-ops
	localparam logic [3:0] CSR_RW = 4'd1;
	localparam logic [3:0] CSR_RC = 4'd3;

	typedef struct packed {
		logic [3:0]         op_class;
		logic [3:0]         sub_op;
		logic signed [31:0] immediate;
		logic [11:0]        csr_address;
		logic               operand_is_immediate;
		logic               has_target;
		logic               wr_class;
		logic               illegal;
	} dec_t;

endpackage

`default_nettype wire

// File: sv/rvid_ifs.sv
// ----------------------------------------------------------------------------
// rvid_ifs - RV32I decoder channel interfaces
// Instruction channel in, decoded-item channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvid_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_pc;
	logic [31:0] instr_word;

	modport source (output valid, output instr_pc, output instr_word, input ready);
	modport sink   (input valid, input instr_pc, input instr_word, output ready);
endinterface

interface rvid_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         op_class;
	logic [3:0]         sub_op;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic signed [31:0] immediate;
	logic [11:0]        csr_address;
	logic               operand_is_immediate;
	logic [31:0]        target_address;
	logic [31:0]        link_address;
	logic               writes_dest;
	logic               illegal;

	modport source (
		output valid, input ready,
		output op_class, output sub_op, output dest_reg, output src1_reg,
		output src2_reg, output immediate, output csr_address,
		output operand_is_immediate, output target_address,
		output link_address, output writes_dest, output illegal
	);
	modport sink (
		input valid, output ready,
		input op_class, input sub_op, input dest_reg, input src1_reg,
		input src2_reg, input immediate, input csr_address,
		input operand_is_immediate, input target_address,
		input link_address, input writes_dest, input illegal
	);
endinterface

`default_nettype wire

// File: sv/rvid_decode.sv
// ----------------------------------------------------------------------------
// rvid_decode - RV32I field decode
// Class, sub-op, immediate, CSR fields and illegal detection for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module rvid_decode (
	input  wire logic [31:0]   word,
	input  wire logic          host_syscall_mode,
	output rvid_pkg::dec_t     dec
);

	logic [6:0]         opc;
	logic [6:0]         f7;
	logic [2:0]         f3;
	logic signed [31:0] imm_i;
	logic signed [31:0] imm_s;
	logic signed [31:0] imm_b;
	logic signed [31:0] imm_j;
	logic signed [31:0] imm_u;
	logic signed [31:0] shamt;

	assign opc   = word[6:0];
	assign f3    = word[14:12];
	assign f7    = word[31:25];
	assign imm_i = {{20{word[31]}}, word[31:20]};
	assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
	assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
	assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
	assign imm_u = {word[31:12], 12'd0};
	assign shamt = {27'd0, word[24:20]};

	always_comb begin
		dec = '0;
		case (opc)
			rvid_pkg::OPC_OP: begin
				dec.op_class = rvid_pkg::CLS_ALU_REG;
				dec.wr_class = 1'b1;
				if (f7 == rvid_pkg::F7_BASE) begin
					dec.sub_op = {1'b0, f3};
				end else if (f7 == rvid_pkg::F7_ALT && f3 == rvid_pkg::F3_ADD) begin
					dec.sub_op = rvid_pkg::ALU_SUB;
				end else if (f7 == rvid_pkg::F7_ALT && f3 == rvid_pkg::F3_SR) begin
					dec.sub_op = rvid_pkg::ALU_SRA;
				end else begin
					dec.illegal = 1'b1;   // M extension and unknown funct7
				end
			end
			rvid_pkg::OPC_OP_IMM: begin
				dec.op_class = rvid_pkg::CLS_ALU_IMM;
				dec.wr_class = 1'b1;
				if (f3 == rvid_pkg::F3_SLL || f3 == rvid_pkg::F3_SR) begin
					dec.immediate = shamt;
					dec.sub_op = (f3 == rvid_pkg::F3_SR && f7 == rvid_pkg::F7_ALT)
						? rvid_pkg::ALU_SRA : {1'b0, f3};
				end else begin
					dec.immediate = imm_i;
					dec.sub_op    = {1'b0, f3};
				end
			end
			rvid_pkg::OPC_LOAD: begin
				dec.op_class  = rvid_pkg::CLS_LOAD;
				dec.wr_class  = 1'b1;
				dec.sub_op    = {1'b0, f3};
				dec.immediate = imm_i;
				dec.illegal   = (f3 inside {3'd3, 3'd6, 3'd7});
			end
			rvid_pkg::OPC_STORE: begin
				dec.op_class  = rvid_pkg::CLS_STORE;
				dec.sub_op    = {1'b0, f3};
				dec.immediate = imm_s;
				dec.illegal   = (f3 > 3'd2);
			end
			rvid_pkg::OPC_LUI: begin
				dec.op_class  = rvid_pkg::CLS_LUI;
				dec.wr_class  = 1'b1;
				dec.immediate = imm_u;
			end
			rvid_pkg::OPC_AUIPC: begin
				dec.op_class   = rvid_pkg::CLS_AUIPC;
				dec.wr_class   = 1'b1;
				dec.immediate  = imm_u;
				dec.has_target = 1'b1;
				dec.illegal    = (word[11:7] == 5'd0);
			end
			rvid_pkg::OPC_JAL: begin
				dec.op_class   = rvid_pkg::CLS_JAL;
				dec.wr_class   = 1'b1;
				dec.immediate  = imm_j;
				dec.has_target = 1'b1;
			end
			rvid_pkg::OPC_JALR: begin
				dec.op_class  = rvid_pkg::CLS_JALR;
				dec.wr_class  = 1'b1;
				dec.immediate = imm_i;
			end
			rvid_pkg::OPC_BRANCH: begin
				dec.op_class   = rvid_pkg::CLS_BRANCH;
				dec.sub_op     = {1'b0, f3};
				dec.immediate  = imm_b;
				dec.has_target = 1'b1;
				dec.illegal    = (f3 inside {3'd2, 3'd3});
			end
			rvid_pkg::OPC_SYSTEM: begin
				if (f3 == rvid_pkg::F3_PRIV || f3 == rvid_pkg::F3_HLV) begin
					dec.op_class = rvid_pkg::CLS_SYSTEM;
					case (word)
						rvid_pkg::W_ECALL:  dec.sub_op = host_syscall_mode
							? rvid_pkg::SYS_HOSTCALL : rvid_pkg::SYS_ECALL;
						rvid_pkg::W_EBREAK: dec.sub_op = rvid_pkg::SYS_EBREAK;
						rvid_pkg::W_SRET:   dec.sub_op = rvid_pkg::SYS_SRET;
						rvid_pkg::W_MRET:   dec.sub_op = rvid_pkg::SYS_MRET;
						rvid_pkg::W_WFI:    dec.sub_op = rvid_pkg::SYS_WFI;
						default:            dec.illegal = 1'b1;
					endcase
				end else begin
					dec.op_class             = rvid_pkg::CLS_CSR;
					dec.wr_class             = 1'b1;
					dec.sub_op               = {2'b00, f3[1:0]};
					dec.operand_is_immediate = f3[2];
					dec.csr_address          = word[31:20];
				end
			end
			default: begin
				dec.illegal = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/rvid_addgen.sv
// ----------------------------------------------------------------------------
// rvid_addgen - RV32I address generation
// Target (pc + immediate, when the class has one) and link (pc + 4).
// ----------------------------------------------------------------------------
`default_nettype none

module rvid_addgen (
	input  wire logic [31:0]        pc,
	input  wire logic signed [31:0] imm,
	input  wire logic               has_target,
	output logic [31:0]             target,
	output logic [31:0]             link
);

	assign target = has_target ? (pc + unsigned'(imm)) : 32'd0;
	assign link   = pc + 32'd4;

endmodule

`default_nettype wire

// File: sv/rv32i_instruction_decoder_top.sv
// Path: an accepted item is registered in s1, s2 and s3; s3 drives the decoded item out.
// Throughput: one item per cycle; the pipeline only stalls where the output is not taken.
// Stages: s1 field decode, s2 address adders and write flag, s3 output register.
// Reset: arst_n clears all stage valid bits and host_syscall_mode; payload is not reset.
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_top - RV32I instruction decoder
// Three-stage valid/ready pipeline decoding one RV32I word per cycle while the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_instruction_decoder_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_wen,
	input  wire logic  cfg_wdata,
	rvid_in_if.sink    instr_in,
	rvid_out_if.source dec_out
);

	// ------------------------------------------------------------------
	// Mode register: the user must see that it is only written while the pipeline
	// is empty, so stage 1 can read it directly; the block does not enforce it.
	// ------------------------------------------------------------------
	logic host_syscall_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_syscall_mode_q <= 1'b0;
		end else if (cfg_wen) begin
			host_syscall_mode_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Per-stage backpressure: a stage may load when empty or when the next
	// stage is moving. Bubbles are squeezed out.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3       = !valid_s3 || dec_out.ready;
	assign ready_s2       = !valid_s2 || ready_s3;
	assign ready_s1       = !valid_s1 || ready_s2;
	assign instr_in.ready = ready_s1;

	// ------------------------------------------------------------------
	// Stage 1: field decode of the incoming word
	// ------------------------------------------------------------------
	rvid_pkg::dec_t dec_c;
	rvid_pkg::dec_t dec_s1;
	logic [31:0]    pc_s1;
	logic [14:0]    regs_s1;   // {rd, rs1, rs2}

	rvid_decode u_decode (
		.word              (instr_in.instr_word),
		.host_syscall_mode (host_syscall_mode_q),
		.dec               (dec_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= instr_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr_in.valid && ready_s1) begin
			dec_s1  <= dec_c;
			pc_s1   <= instr_in.instr_pc;
			regs_s1 <= {instr_in.instr_word[11:7], instr_in.instr_word[19:15],
				instr_in.instr_word[24:20]};
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: target / link adders, final destination-write flag
	// ------------------------------------------------------------------
	logic [31:0]    target_c, link_c;
	rvid_pkg::dec_t dec_s2;
	logic [14:0]    regs_s2;
	logic [31:0]    target_s2, link_s2;
	logic           wr_s2;

	rvid_addgen u_addgen (
		.pc         (pc_s1),
		.imm        (dec_s1.immediate),
		.has_target (dec_s1.has_target),
		.target     (target_c),
		.link       (link_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			dec_s2    <= dec_s1;
			regs_s2   <= regs_s1;
			target_s2 <= target_c;
			link_s2   <= link_c;
			// x0 is never reported as written
			wr_s2     <= dec_s1.wr_class && (regs_s1[14:10] != 5'd0) && !dec_s1.illegal;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: output register, holds while the sink stalls
	// ------------------------------------------------------------------
	rvid_pkg::dec_t dec_s3;
	logic [14:0]    regs_s3;
	logic [31:0]    target_s3, link_s3;
	logic           wr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			dec_s3    <= dec_s2;
			regs_s3   <= regs_s2;
			target_s3 <= target_s2;
			link_s3   <= link_s2;
			wr_s3     <= wr_s2;
		end
	end

	assign dec_out.valid                = valid_s3;
	assign dec_out.op_class             = dec_s3.op_class;
	assign dec_out.sub_op               = dec_s3.sub_op;
	assign dec_out.dest_reg             = regs_s3[14:10];
	assign dec_out.src1_reg             = regs_s3[9:5];
	assign dec_out.src2_reg             = regs_s3[4:0];
	assign dec_out.immediate            = dec_s3.immediate;
	assign dec_out.csr_address          = dec_s3.csr_address;
	assign dec_out.operand_is_immediate = dec_s3.operand_is_immediate;
	assign dec_out.target_address       = target_s3;
	assign dec_out.link_address         = link_s3;
	assign dec_out.writes_dest          = wr_s3;
	assign dec_out.illegal              = dec_s3.illegal;

endmodule

`default_nettype wire

// File: sv/rvid_checker.sv
// ----------------------------------------------------------------------------
// rvid_checker - RV32I decoder port checks
// Output handshake and field consistency of decoded items.
// ----------------------------------------------------------------------------
`default_nettype none

module rvid_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  op_class,
	input wire logic [3:0]  sub_op,
	input wire logic [4:0]  dest_reg,
	input wire logic [31:0] target_address,
	input wire logic        writes_dest,
	input wire logic        illegal
);

	// a stalled item stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(op_class)
			&& $stable(target_address))
		else $error("output item changed while stalled");

	// never a write to x0 or from an illegal word
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && writes_dest |-> dest_reg != 5'd0 && !illegal)
		else $error("write flag with x0 or illegal word");

	// only branch, jal and auipc carry a target
	a_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_class != rvid_pkg::CLS_BRANCH && op_class != rvid_pkg::CLS_JAL
			&& op_class != rvid_pkg::CLS_AUIPC |-> target_address == 32'd0)
		else $error("target on a class without one");

	// csr items are rw, rs or rc, and always write-capable unless x0
	a_csr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_class == rvid_pkg::CLS_CSR |->
			sub_op >= rvid_pkg::CSR_RW && sub_op <= rvid_pkg::CSR_RC
			&& writes_dest == (dest_reg != 5'd0))
		else $error("bad csr decode");

endmodule

bind rv32i_instruction_decoder_top rvid_checker u_rvid_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (dec_out.valid),
	.out_ready      (dec_out.ready),
	.op_class       (dec_out.op_class),
	.sub_op         (dec_out.sub_op),
	.dest_reg       (dec_out.dest_reg),
	.target_address (dec_out.target_address),
	.writes_dest    (dec_out.writes_dest),
	.illegal        (dec_out.illegal)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - RV32I instruction decoder testbench
// A directed table of corner-case words, then random phases of instruction
// items in both syscall modes. Each decoded item is checked field by field
// against a golden row or the bench decoder; random idles on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	import rvid_pkg::*;

	// pipeline depth quoted at the head of the decoder
	localparam int DECODE_LATENCY = 3;
	localparam int CYCLE_LIMIT    = 600_000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 222;
	localparam int LONG_HOLD      = 400;
	localparam int N_DIRECTED     = 26;

	// decoder codes that the package does not name
	localparam logic [3:0] SUB_NONE    = 4'd0;
	localparam logic [6:0] F7_MULDIV   = 7'h01;
	localparam logic [2:0] F3_BNE      = 3'd1;
	localparam logic [2:0] F3_WORD     = 3'd2;
	localparam logic [2:0] F3_BLT      = 3'd4;
	localparam logic [2:0] F3_LBU      = 3'd4;
	localparam logic [2:0] F3_LHU      = 3'd5;

	localparam logic [6:0] LEGAL_OPCODES [10] = '{
		OPC_OP, OPC_OP_IMM, OPC_LOAD, OPC_STORE, OPC_LUI,
		OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_SYSTEM
	};
	localparam logic [31:0] SYSTEM_WORDS [5] = '{
		W_ECALL, W_EBREAK, W_SRET, W_MRET, W_WFI
	};

	// one decoded item, field for field as it leaves the block
	typedef struct packed {
		logic [3:0]  op_class;
		logic [3:0]  sub_op;
		logic [4:0]  dest_reg;
		logic [4:0]  src1_reg;
		logic [4:0]  src2_reg;
		logic [31:0] immediate;
		logic [11:0] csr_address;
		logic        operand_is_immediate;
		logic [31:0] target_address;
		logic [31:0] link_address;
		logic        writes_dest;
		logic        illegal;
	} decoded_t;

	// one row of the directed table; golden is used only when typed is set
	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] word;
		logic        mode;
		logic        typed;
		decoded_t    golden;
	} stim_row_t;

	localparam decoded_t NO_GOLDEN = '0;

	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// unknown opcode, every word bit set
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1,
			'{CLS_ALU_REG, SUB_NONE, 5'd31, 5'd31, 5'd31, 32'h0, 12'h0, 1'b0,
			32'h0, 32'h0000_0004, 1'b0, 1'b1}},
		// all-zero word at the top of memory: link wraps to 0
		'{32'hFFFF_FFFC, 32'h0000_0000, 1'b0, 1'b1,
			'{CLS_ALU_REG, SUB_NONE, 5'd0, 5'd0, 5'd0, 32'h0, 12'h0, 1'b0,
			32'h0, 32'h0000_0000, 1'b0, 1'b1}},
		// ecall straight after reset: plain ecall
		'{32'h0000_0100, W_ECALL, 1'b0, 1'b1,
			'{CLS_SYSTEM, SYS_ECALL, 5'd0, 5'd0, 5'd0, 32'h0, 12'h0, 1'b0,
			32'h0, 32'h0000_0104, 1'b0, 1'b0}},
		// mul x1, x2, x3: M extension is rejected
		'{32'h0000_0200, 32'h0231_00B3, 1'b0, 1'b1,
			'{CLS_ALU_REG, SUB_NONE, 5'd1, 5'd2, 5'd3, 32'h0, 12'h0, 1'b0,
			32'h0, 32'h0000_0204, 1'b0, 1'b1}},
		// auipc to x0: decoded, target wraps, but flagged
		'{32'h0000_1000, 32'hFFFF_F017, 1'b0, 1'b1,
			'{CLS_AUIPC, SUB_NONE, 5'd0, 5'd31, 5'd31, 32'hFFFF_F000, 12'h0, 1'b0,
			32'h0, 32'h0000_1004, 1'b0, 1'b1}},
		'{32'h0000_0400, 32'h4020_D0B3, 1'b0, 1'b0, NO_GOLDEN},  // sra
		'{32'h0000_0404, 32'h4000_1033, 1'b0, 1'b0, NO_GOLDEN},  // alt funct7, sll
		'{32'h0000_0408, 32'hFFF3_0293, 1'b0, 1'b0, NO_GOLDEN},  // addi -1
		'{32'h0000_040C, 32'h41F0_D093, 1'b0, 1'b0, NO_GOLDEN},  // srai 31
		'{32'h0000_0410, 32'hFE00_9093, 1'b0, 1'b0, NO_GOLDEN},  // slli, junk funct7
		'{32'h0000_0414, 32'h8000_2083, 1'b0, 1'b0, NO_GOLDEN},  // lw -2048
		'{32'h0000_0418, 32'h0000_3003, 1'b0, 1'b0, NO_GOLDEN},  // load funct3 3
		'{32'h0000_041C, 32'h7E00_2FA3, 1'b0, 1'b0, NO_GOLDEN},  // sw +2047
		'{32'h0000_0420, 32'h0000_7023, 1'b0, 1'b0, NO_GOLDEN},  // store funct3 7
		'{32'h0000_0424, 32'hFFFF_FFB7, 1'b0, 1'b0, NO_GOLDEN},  // lui x31
		'{32'h8000_0000, 32'h8000_0097, 1'b0, 1'b0, NO_GOLDEN},  // auipc wraps
		'{32'h0000_0010, 32'h8000_00EF, 1'b0, 1'b0, NO_GOLDEN},  // jal most negative
		'{32'h0000_0428, 32'hFFF0_F0E7, 1'b0, 1'b0, NO_GOLDEN},  // jalr funct3 7
		'{32'h0000_0000, 32'h8000_0063, 1'b0, 1'b0, NO_GOLDEN},  // beq -4096
		'{32'h0000_042C, 32'h0000_2063, 1'b0, 1'b0, NO_GOLDEN},  // branch funct3 2
		'{32'hFFFF_F000, 32'h7E00_7FE3, 1'b0, 1'b0, NO_GOLDEN},  // bgeu +4094
		'{32'h0000_0430, W_EBREAK,     1'b0, 1'b0, NO_GOLDEN},
		'{32'h0000_0434, 32'h0020_0073, 1'b0, 1'b0, NO_GOLDEN},  // unknown system
		'{32'h0000_0438, 32'hFFF1_10F3, 1'b0, 1'b0, NO_GOLDEN},  // csrrw 0xfff
		'{32'h0000_043C, 32'h300F_E2F3, 1'b0, 1'b0, NO_GOLDEN},  // csrrsi zimm 31
		// ecall once host syscall mode is on
		'{32'h7FFF_FFFC, W_ECALL, 1'b1, 1'b1,
			'{CLS_SYSTEM, SYS_HOSTCALL, 5'd0, 5'd0, 5'd0, 32'h0, 12'h0, 1'b0,
			32'h0, 32'h8000_0000, 1'b0, 1'b0}}
	};

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic cfg_wdata;

	rvid_in_if  instr_if ();
	rvid_out_if dec_if ();

	rv32i_instruction_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.instr_in  (instr_if),
		.dec_out   (dec_if)
	);

	decoded_t expected_decodes [$];   // oldest first
	logic     host_mode;              // bench copy of host_syscall_mode
	bit       idle_enabled;           // cleared for back-to-back stretches
	bit       hold_request;           // asks the receiver for one long hold-off
	int       mismatch_count;
	int       cycle_count;

	// ------------------------------------------------------------------------
	// Bench decoder: same field extraction, written out per opcode.
	// ------------------------------------------------------------------------
	function automatic decoded_t decode_rv32i(input logic [31:0] pc, input logic [31:0] w,
			input logic syscall_mode);
		decoded_t    d;
		logic [6:0]  opc;
		logic [6:0]  f7;
		logic [2:0]  f3;
		logic [31:0] imm_i;
		logic        wr_class;
		logic        has_target;
		d          = '0;
		opc        = w[6:0];
		f3         = w[14:12];
		f7         = w[31:25];
		imm_i      = {{20{w[31]}}, w[31:20]};
		wr_class   = 1'b0;
		has_target = 1'b0;
		// register fields and the link address come straight from the item
		d.dest_reg     = w[11:7];
		d.src1_reg     = w[19:15];
		d.src2_reg     = w[24:20];
		d.link_address = pc + 32'd4;
		case (opc)
			OPC_OP: begin
				d.op_class = CLS_ALU_REG;
				wr_class   = 1'b1;
				if (f7 == F7_BASE)
					d.sub_op = {1'b0, f3};
				else if (f7 == F7_ALT && f3 == F3_ADD)
					d.sub_op = ALU_SUB;
				else if (f7 == F7_ALT && f3 == F3_SR)
					d.sub_op = ALU_SRA;
				else
					d.illegal = 1'b1;
			end
			OPC_OP_IMM: begin
				d.op_class = CLS_ALU_IMM;
				wr_class   = 1'b1;
				if (f3 == F3_SLL || f3 == F3_SR) begin
					// shift amount only; funct7 just picks srai
					d.immediate = {27'd0, w[24:20]};
					d.sub_op    = (f3 == F3_SR && f7 == F7_ALT) ? ALU_SRA : {1'b0, f3};
				end else begin
					d.immediate = imm_i;
					d.sub_op    = {1'b0, f3};
				end
			end
			OPC_LOAD: begin
				d.op_class  = CLS_LOAD;
				wr_class    = 1'b1;
				d.sub_op    = {1'b0, f3};
				d.immediate = imm_i;
				d.illegal   = !(f3 <= F3_WORD || f3 == F3_LBU || f3 == F3_LHU);
			end
			OPC_STORE: begin
				d.op_class  = CLS_STORE;
				d.sub_op    = {1'b0, f3};
				d.immediate = {imm_i[31:5], w[11:7]};
				d.illegal   = f3 > F3_WORD;
			end
			OPC_LUI: begin
				d.op_class  = CLS_LUI;
				wr_class    = 1'b1;
				d.immediate = {w[31:12], 12'd0};
			end
			OPC_AUIPC: begin
				d.op_class  = CLS_AUIPC;
				wr_class    = 1'b1;
				has_target  = 1'b1;
				d.immediate = {w[31:12], 12'd0};
				d.illegal   = w[11:7] == 5'd0;
			end
			OPC_JAL: begin
				d.op_class  = CLS_JAL;
				wr_class    = 1'b1;
				has_target  = 1'b1;
				d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_JALR: begin
				d.op_class  = CLS_JALR;
				wr_class    = 1'b1;
				d.immediate = imm_i;
			end
			OPC_BRANCH: begin
				d.op_class  = CLS_BRANCH;
				has_target  = 1'b1;
				d.sub_op    = {1'b0, f3};
				d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				d.illegal   = f3 > F3_BNE && f3 < F3_BLT;
			end
			OPC_SYSTEM: begin
				if (f3 == F3_PRIV || f3 == F3_HLV) begin
					// only five exact words are known
					d.op_class = CLS_SYSTEM;
					case (w)
						W_ECALL:  d.sub_op = syscall_mode ? SYS_HOSTCALL : SYS_ECALL;
						W_EBREAK: d.sub_op = SYS_EBREAK;
						W_SRET:   d.sub_op = SYS_SRET;
						W_MRET:   d.sub_op = SYS_MRET;
						W_WFI:    d.sub_op = SYS_WFI;
						default:  d.illegal = 1'b1;
					endcase
				end else begin
					d.op_class             = CLS_CSR;
					wr_class               = 1'b1;
					d.sub_op               = {2'd0, f3[1:0]};
					d.operand_is_immediate = f3[2];
					d.csr_address          = w[31:20];
				end
			end
			default: begin
				d.illegal = 1'b1;
			end
		endcase
		if (has_target)
			d.target_address = pc + d.immediate;
		d.writes_dest = wr_class && d.dest_reg != 5'd0 && !d.illegal;
		return d;
	endfunction

	// ------------------------------------------------------------------------
	// Random instruction words: mostly well-formed encodings with random
	// content, plus exact system words and raw noise.
	// ------------------------------------------------------------------------
	function automatic logic [31:0] random_instr_word();
		logic [31:0] w;
		int          pick;
		w    = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return w;
		if (pick < 18)
			return SYSTEM_WORDS[$urandom_range(0, 4)];
		w[6:0] = LEGAL_OPCODES[$urandom_range(0, 9)];
		case (w[6:0])
			OPC_OP: begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					w[31:25] = F7_BASE;
				else if (pick < 8)
					w[31:25] = F7_ALT;
				else if (pick == 8)
					w[31:25] = F7_MULDIV;
			end
			OPC_OP_IMM: begin
				if ($urandom_range(0, 1) == 0)
					w[31:25] = ($urandom_range(0, 1) == 0) ? F7_ALT : F7_BASE;
			end
			OPC_SYSTEM: begin
				// steer some toward near-miss privileged words
				if ($urandom_range(0, 3) == 0)
					w[14:12] = ($urandom_range(0, 1) == 0) ? F3_PRIV : F3_HLV;
			end
			default: ;
		endcase
		// x0 as destination now and then, for the write flag
		if ($urandom_range(0, 7) == 0)
			w[11:7] = 5'd0;
		return w;
	endfunction

	// random pc: full range, some right at the top so that the adders wrap
	function automatic logic [31:0] random_pc();
		if ($urandom_range(0, 9) == 0)
			return 32'hFFFF_FFFC - 32'($urandom_range(0, 64));
		return $urandom();
	endfunction

	// idle length shared by both channels: mostly none, some short, few long
	function automatic int idle_gap();
		int r;
		if (!idle_enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %h, actual %h", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Instruction channel
	// ------------------------------------------------------------------------

	// valid drops for an idle gap set by n; n = 0 keeps it up for the next item
	task automatic sender_idle(input int n);
		if (n > 0) begin
			@(negedge clk);
			instr_if.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// offer one item and hold it until taken; its expectation is queued then
	task automatic offer_instr(input logic [31:0] pc, input logic [31:0] word,
			input logic typed, input decoded_t golden);
		@(negedge clk);
		instr_if.valid      <= 1'b1;
		instr_if.instr_pc   <= pc;
		instr_if.instr_word <= word;
		do @(posedge clk); while (instr_if.ready !== 1'b1);
		expected_decodes.push_back(typed ? golden : decode_rv32i(pc, word, host_mode));
	endtask

	// stop sending and let every outstanding item drain out of the pipe
	task automatic wait_drained();
		@(negedge clk);
		instr_if.valid <= 1'b0;
		while (expected_decodes.size() != 0) @(posedge clk);
		repeat (DECODE_LATENCY + 2) @(posedge clk);
	endtask

	// mode register writes happen only with the pipe empty
	task automatic set_syscall_mode(input logic mode);
		wait_drained();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		host_mode = mode;
	endtask

	// ------------------------------------------------------------------------
	// Clock, watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Decoded-item channel: ready idles at random; one long hold-off on
	// request, long enough for the pipe to fill and push back on the input.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int hold_left;
		int stall_left;
		hold_left    = 0;
		stall_left   = 0;
		dec_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				dec_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				dec_if.ready <= 1'b0;
			end else begin
				dec_if.ready <= 1'b1;
				stall_left = idle_gap();
			end
		end
	end

	// every taken item is checked against the oldest expectation
	always @(posedge clk) begin
		decoded_t exp_item;
		if (arst_n && dec_if.valid === 1'b1 && dec_if.ready === 1'b1) begin
			if (expected_decodes.size() == 0) begin
				$error("decoded item with nothing expected: class %h word fields %h/%h/%h",
					dec_if.op_class, dec_if.dest_reg, dec_if.src1_reg, dec_if.src2_reg);
				mismatch_count++;
			end else begin
				exp_item = expected_decodes.pop_front();
				check_field("op_class", 32'(exp_item.op_class), 32'(dec_if.op_class));
				check_field("sub_op", 32'(exp_item.sub_op), 32'(dec_if.sub_op));
				check_field("dest_reg", 32'(exp_item.dest_reg), 32'(dec_if.dest_reg));
				check_field("src1_reg", 32'(exp_item.src1_reg), 32'(dec_if.src1_reg));
				check_field("src2_reg", 32'(exp_item.src2_reg), 32'(dec_if.src2_reg));
				check_field("immediate", exp_item.immediate, 32'(dec_if.immediate));
				check_field("csr_address", 32'(exp_item.csr_address),
					32'(dec_if.csr_address));
				check_field("operand_is_immediate", 32'(exp_item.operand_is_immediate),
					32'(dec_if.operand_is_immediate));
				check_field("target_address", exp_item.target_address,
					dec_if.target_address);
				check_field("link_address", exp_item.link_address, dec_if.link_address);
				check_field("writes_dest", 32'(exp_item.writes_dest),
					32'(dec_if.writes_dest));
				check_field("illegal", 32'(exp_item.illegal), 32'(dec_if.illegal));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		arst_n              = 1'b0;
		cfg_wen             = 1'b0;
		cfg_wdata           = 1'b0;
		instr_if.valid      = 1'b0;
		instr_if.instr_pc   = 32'd0;
		instr_if.instr_word = 32'd0;
		host_mode           = 1'b0;
		idle_enabled        = 1'b1;
		hold_request        = 1'b0;
		mismatch_count      = 0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed table; the mode is the reset value until a row asks otherwise
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].mode != host_mode)
				set_syscall_mode(DIRECTED[i].mode);
			sender_idle(idle_gap());
			offer_instr(DIRECTED[i].pc, DIRECTED[i].word, DIRECTED[i].typed,
				DIRECTED[i].golden);
		end

		// random phases, mode flipping each time; phase 1 brings the long
		// receiver hold-off, phase 3 runs back to back, phase 4 drains midway
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_syscall_mode(phase % 2 == 0 ? 1'b0 : 1'b1);
			idle_enabled = (phase != 3);
			if (phase == 1)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 4 && n == PHASE_ITEMS / 2)
					wait_drained();
				sender_idle(idle_gap());
				offer_instr(random_pc(), random_instr_word(), 1'b0, NO_GOLDEN);
			end
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
